// ----- rtl/jsv_pkg.sv -----
// ----------------------------------------------------------------------------
// jsv_pkg: shared types and constants of the JSON syntax validator
// Parse phases, byte classes, queue word layout and literal spelling.
// ----------------------------------------------------------------------------
package jsv_pkg;

  // Parse phase of the back end.
  typedef enum logic [3:0] {
    PH_VALUE,
    PH_ARR_FIRST,
    PH_OBJ_FIRST,
    PH_OBJ_KEY,
    PH_KEY_STR,
    PH_KEY_ESC,
    PH_COLON,
    PH_VAL_STR,
    PH_VAL_ESC,
    PH_NUM_SIGN,
    PH_NUM_INT,
    PH_NUM_FRAC,
    PH_LIT_TRUE,
    PH_LIT_FALSE,
    PH_LIT_NULL,
    PH_AFTER
  } phase_e;

  // Byte classes produced by the front end.
  typedef enum logic [4:0] {
    CL_OTHER,
    CL_TERM,
    CL_WS,
    CL_QUOTE,
    CL_BSLASH,
    CL_LBRACE,
    CL_RBRACE,
    CL_LBRACK,
    CL_RBRACK,
    CL_COMMA,
    CL_COLON,
    CL_MINUS,
    CL_DIGIT,
    CL_DOT,
    CL_LIT_T,
    CL_LIT_F,
    CL_LIT_N
  } class_e;

  // One queue word: the class and the raw byte (needed for literal matching).
  typedef struct packed {
    class_e     cls;
    logic [7:0] chr;
  } item_t;

  // Status of the back end, used by the checks in the top level.
  typedef struct packed {
    logic term_fire;
    logic err;
  } back_stat_t;

  localparam logic KIND_ARRAY  = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  localparam int unsigned LIT_PROG_W = 3;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Expected byte at position idx of the literal spelled by phase ph.
  // Positions past the end return NUL, which never matches a non-terminator.
  function automatic logic [7:0] lit_char(phase_e ph, logic [LIT_PROG_W-1:0] idx);
    logic [7:0] c;
    c = CH_NUL;
    unique case (ph)
      PH_LIT_TRUE: begin
        unique case (idx)
          3'd0:    c = CH_T;
          3'd1:    c = CH_R;
          3'd2:    c = CH_U;
          3'd3:    c = CH_E;
          default: c = CH_NUL;
        endcase
      end
      PH_LIT_FALSE: begin
        unique case (idx)
          3'd0:    c = CH_F;
          3'd1:    c = CH_A;
          3'd2:    c = CH_L;
          3'd3:    c = CH_S;
          3'd4:    c = CH_E;
          default: c = CH_NUL;
        endcase
      end
      PH_LIT_NULL: begin
        unique case (idx)
          3'd0:    c = CH_N;
          3'd1:    c = CH_U;
          3'd2:    c = CH_L;
          3'd3:    c = CH_L;
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // Length of the literal spelled by phase ph.
  function automatic logic [LIT_PROG_W-1:0] lit_len(phase_e ph);
    return (ph == PH_LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

// ----- rtl/jsv_ram.sv -----
// ----------------------------------------------------------------------------
// jsv_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jsv_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/jsv_front.sv -----
// ----------------------------------------------------------------------------
// jsv_front: byte intake, classification and decoupling queue
// Classifies each accepted byte and holds it in a two-word queue.
// ----------------------------------------------------------------------------
module jsv_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,   // [7:0] char_byte
  output logic          q_valid_o,
  output jsv_pkg::item_t q_item_o,
  input  logic          q_pop_i
);
  import jsv_pkg::*;

  class_e     cls;
  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  always_comb begin
    priority if (s_axis_tdata_i == CH_NUL) begin
      cls = CL_TERM;
    end else if (s_axis_tdata_i == CH_SPACE || s_axis_tdata_i == CH_TAB ||
                 s_axis_tdata_i == CH_LF || s_axis_tdata_i == CH_CR) begin
      cls = CL_WS;
    end else if (s_axis_tdata_i >= CH_ZERO && s_axis_tdata_i <= CH_NINE) begin
      cls = CL_DIGIT;
    end else if (s_axis_tdata_i == CH_QUOTE) begin
      cls = CL_QUOTE;
    end else if (s_axis_tdata_i == CH_BSLASH) begin
      cls = CL_BSLASH;
    end else if (s_axis_tdata_i == CH_LBRACE) begin
      cls = CL_LBRACE;
    end else if (s_axis_tdata_i == CH_RBRACE) begin
      cls = CL_RBRACE;
    end else if (s_axis_tdata_i == CH_LBRACK) begin
      cls = CL_LBRACK;
    end else if (s_axis_tdata_i == CH_RBRACK) begin
      cls = CL_RBRACK;
    end else if (s_axis_tdata_i == CH_COMMA) begin
      cls = CL_COMMA;
    end else if (s_axis_tdata_i == CH_COLON) begin
      cls = CL_COLON;
    end else if (s_axis_tdata_i == CH_MINUS) begin
      cls = CL_MINUS;
    end else if (s_axis_tdata_i == CH_DOT) begin
      cls = CL_DOT;
    end else if (s_axis_tdata_i == CH_T) begin
      cls = CL_LIT_T;
    end else if (s_axis_tdata_i == CH_F) begin
      cls = CL_LIT_F;
    end else if (s_axis_tdata_i == CH_N) begin
      cls = CL_LIT_N;
    end else begin
      cls = CL_OTHER;
    end
  end

  assign s_axis_tready_o = (count_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = q_pop_i && (count_q != 2'd0);
  assign q_valid_o       = (count_q != 2'd0);
  assign q_item_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cls: cls, chr: s_axis_tdata_i};
    end
  end

endmodule

// ----- rtl/jsv_back.sv -----
// ----------------------------------------------------------------------------
// jsv_back: parse state machine, nesting stack and result register
// Executes one classified byte per cycle while the result is not stalled, and registers its status word.
// ----------------------------------------------------------------------------
module jsv_back #(
  parameter int unsigned MAX_NEST_DEPTH = 64,
  parameter int unsigned DW = $clog2(MAX_NEST_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  jsv_pkg::item_t        q_item_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  output logic [DW-1:0]         depth_o,
  output jsv_pkg::back_stat_t   stat_o
);
  import jsv_pkg::*;

  localparam int unsigned AW = (MAX_NEST_DEPTH > 1) ? $clog2(MAX_NEST_DEPTH) : 1;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST_DEPTH);

  phase_e                phase_q, phase_d;
  logic [LIT_PROG_W-1:0] prog_q, prog_d;
  logic [DW-1:0]         depth_q, depth_d;
  logic                  err_q, err_d;
  logic                  top_q, top_d;
  logic                  below;

  logic                  fire, term;
  logic                  start_req, after_req, push_req, pop_req, push_kind;
  phase_e                push_phase;
  logic                  ram_we;
  logic [DW-1:0]         rd_full;

  logic                  out_valid_q;
  logic                  fin_q, fin_d;
  logic                  doc_q, doc_d;
  logic                  errout_q, errout_d;
  logic [6:0]            dout_q, dout_d;
  logic [DW+6:0]         depth_ext;
  logic                  ends_ok;

  assign fire    = q_valid_i && (!out_valid_q || m_axis_tready_i);
  assign q_pop_o = fire;
  assign term    = (q_item_i.cls == CL_TERM);

  // Next state.
  always_comb begin
    phase_d    = phase_q;
    prog_d     = prog_q;
    depth_d    = depth_q;
    err_d      = err_q;
    top_d      = top_q;
    start_req  = 1'b0;
    after_req  = 1'b0;
    push_req   = 1'b0;
    pop_req    = 1'b0;
    push_kind  = KIND_ARRAY;
    push_phase = phase_q;
    ram_we     = 1'b0;
    if (fire) begin
      if (term) begin
        phase_d = PH_VALUE;
        prog_d  = '0;
        depth_d = '0;
        err_d   = 1'b0;
      end else if (!err_q) begin
        unique case (phase_q)
          PH_VALUE: begin
            start_req = (q_item_i.cls != CL_WS);
          end
          PH_ARR_FIRST: begin
            if (q_item_i.cls == CL_RBRACK) begin
              pop_req = 1'b1;
            end else if (q_item_i.cls != CL_WS) begin
              start_req = 1'b1;
            end
          end
          PH_OBJ_FIRST: begin
            if (q_item_i.cls == CL_RBRACE) begin
              pop_req = 1'b1;
            end else if (q_item_i.cls == CL_QUOTE) begin
              phase_d = PH_KEY_STR;
            end else if (q_item_i.cls != CL_WS) begin
              err_d = 1'b1;
            end
          end
          PH_OBJ_KEY: begin
            if (q_item_i.cls == CL_QUOTE) begin
              phase_d = PH_KEY_STR;
            end else if (q_item_i.cls != CL_WS) begin
              err_d = 1'b1;
            end
          end
          PH_KEY_STR: begin
            if (q_item_i.cls == CL_QUOTE) begin
              phase_d = PH_COLON;
            end else if (q_item_i.cls == CL_BSLASH) begin
              phase_d = PH_KEY_ESC;
            end
          end
          PH_KEY_ESC: begin
            phase_d = PH_KEY_STR;
          end
          PH_COLON: begin
            if (q_item_i.cls == CL_COLON) begin
              phase_d = PH_VALUE;
            end else if (q_item_i.cls != CL_WS) begin
              err_d = 1'b1;
            end
          end
          PH_VAL_STR: begin
            if (q_item_i.cls == CL_QUOTE) begin
              phase_d = PH_AFTER;
            end else if (q_item_i.cls == CL_BSLASH) begin
              phase_d = PH_VAL_ESC;
            end
          end
          PH_VAL_ESC: begin
            phase_d = PH_VAL_STR;
          end
          PH_NUM_SIGN: begin
            if (q_item_i.cls == CL_DIGIT) begin
              phase_d = PH_NUM_INT;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_NUM_INT: begin
            if (q_item_i.cls == CL_DOT) begin
              phase_d = PH_NUM_FRAC;
            end else if (q_item_i.cls != CL_DIGIT) begin
              phase_d   = PH_AFTER;
              after_req = 1'b1;
            end
          end
          PH_NUM_FRAC: begin
            if (q_item_i.cls != CL_DIGIT) begin
              phase_d   = PH_AFTER;
              after_req = 1'b1;
            end
          end
          PH_LIT_TRUE, PH_LIT_FALSE, PH_LIT_NULL: begin
            if (q_item_i.chr != lit_char(phase_q, prog_q)) begin
              err_d = 1'b1;
            end else if (prog_q + 3'd1 == lit_len(phase_q)) begin
              prog_d  = '0;
              phase_d = PH_AFTER;
            end else begin
              prog_d = prog_q + 3'd1;
            end
          end
          PH_AFTER: begin
            after_req = 1'b1;
          end
        endcase

        if (start_req) begin
          unique case (q_item_i.cls)
            CL_QUOTE:  phase_d = PH_VAL_STR;
            CL_LBRACE: begin
              push_req   = 1'b1;
              push_kind  = KIND_OBJECT;
              push_phase = PH_OBJ_FIRST;
            end
            CL_LBRACK: begin
              push_req   = 1'b1;
              push_kind  = KIND_ARRAY;
              push_phase = PH_ARR_FIRST;
            end
            CL_MINUS:  phase_d = PH_NUM_SIGN;
            CL_DIGIT:  phase_d = PH_NUM_INT;
            CL_LIT_T: begin
              phase_d = PH_LIT_TRUE;
              prog_d  = 3'd1;
            end
            CL_LIT_F: begin
              phase_d = PH_LIT_FALSE;
              prog_d  = 3'd1;
            end
            CL_LIT_N: begin
              phase_d = PH_LIT_NULL;
              prog_d  = 3'd1;
            end
            default:   err_d = 1'b1;
          endcase
        end

        // A completed value: whitespace, a separator or the closing bracket.
        if (after_req && q_item_i.cls != CL_WS) begin
          if (depth_q == '0) begin
            err_d = 1'b1;
          end else if (q_item_i.cls == CL_COMMA) begin
            phase_d = (top_q == KIND_OBJECT) ? PH_OBJ_KEY : PH_VALUE;
          end else if ((top_q == KIND_OBJECT && q_item_i.cls == CL_RBRACE) ||
                       (top_q == KIND_ARRAY && q_item_i.cls == CL_RBRACK)) begin
            pop_req = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end

        if (push_req) begin
          if (depth_q == DEPTH_MAX) begin
            err_d = 1'b1;
          end else begin
            ram_we  = 1'b1;
            depth_d = depth_q + DW'(1);
            top_d   = push_kind;
            phase_d = push_phase;
          end
        end

        if (pop_req) begin
          if (depth_q != '0) begin
            depth_d = depth_q - DW'(1);
            top_d   = below;
          end
          phase_d = PH_AFTER;
        end
      end
    end
  end

  // Result word.
  always_comb begin
    ends_ok = (phase_q == PH_AFTER) || (phase_q == PH_NUM_INT) ||
              (phase_q == PH_NUM_FRAC);
    if (term) begin
      fin_d     = 1'b1;
      doc_d     = !err_q && ends_ok && (depth_q == '0);
      errout_d  = !doc_d;
      depth_ext = {7'b0, depth_q};
    end else begin
      fin_d     = 1'b0;
      doc_d     = 1'b0;
      errout_d  = err_d;
      depth_ext = {7'b0, depth_d};
    end
    dout_d = depth_ext[6:0];
  end

  // The stack RAM holds every pushed kind; the read port keeps the entry
  // just below the top ready for the next pop.
  assign rd_full = (depth_d >= DW'(2)) ? depth_d - DW'(2) : '0;

  jsv_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NEST_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (depth_q[AW-1:0]),
    .wdata_i (push_kind),
    .raddr_i (rd_full[AW-1:0]),
    .rdata_o (below)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_VALUE;
      prog_q      <= '0;
      depth_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      prog_q  <= prog_d;
      depth_q <= depth_d;
      err_q   <= err_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (fire) begin
      fin_q    <= fin_d;
      doc_q    <= doc_d;
      errout_q <= errout_d;
      dout_q   <= dout_d;
    end
  end

  assign m_axis_tvalid_o  = out_valid_q;
  assign m_axis_tlast_o   = fin_q;
  assign m_axis_tdata_o   = {7'b0, dout_q, errout_q, doc_q};
  assign depth_o          = depth_q;
  assign stat_o.term_fire = fire && term;
  assign stat_o.err       = err_q;

endmodule

// ----- rtl/json_syntax_validator.sv -----
// ----------------------------------------------------------------------------
// json_syntax_validator: streaming JSON syntax checker, one byte per word
// Data path: a byte taken is written into the two-word queue; the parser then
// takes it from the queue and writes its word into the result register.
// A stalled result fills the two-word queue.
// One byte per cycle sustained while the result stream does not stall; the parse
// state machine resolves each byte, including any stack push or pop, as it takes it.
// Reset: asynchronous, active low; the parser starts expecting a top-level
// value with an empty stack, and no clearing pass over the stack is needed.
// ----------------------------------------------------------------------------
module json_syntax_validator #(
  parameter int unsigned MAX_NEST_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream of text bytes; a zero byte ends the document.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  // Result stream, one word for each byte taken.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] document_valid, [1] error_seen,
                                        // [8:2] nesting_depth, [15:9] zero
  output logic        m_axis_tlast_o    // finished
);
  import jsv_pkg::*;

  localparam int unsigned DW = $clog2(MAX_NEST_DEPTH + 1);

  // The front end classifies bytes and queues them; the back end runs the
  // parser and holds the result register, so either side can stall alone.
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  logic [DW-1:0] depth;
  back_stat_t stat;

  jsv_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  jsv_back #(
    .MAX_NEST_DEPTH (MAX_NEST_DEPTH),
    .DW             (DW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .depth_o         (depth),
    .stat_o          (stat)
  );

`ifndef SYNTH
  // The open-container count never passes the stack depth.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth <= DW'(MAX_NEST_DEPTH))
    else $error("nesting depth beyond stack size");

  // A terminator returns the parser to its reset state.
  a_term_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.term_fire |=> (depth == '0) && !stat.err)
    else $error("state not cleared after terminator");

  // A valid verdict carries no error and no open containers.
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o && m_axis_tdata_o[0]) |->
      (!m_axis_tdata_o[1] && m_axis_tdata_o[8:2] == 7'd0))
    else $error("inconsistent valid verdict");
`endif

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the JSON syntax validator
// Streams short JSON documents, broken documents and noise into the block,
// one byte per word, with random gaps on the input and random back-pressure
// on the result stream. A bench-side parser predicts the status word of every
// byte, and each result word is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
  import jsv_pkg::*;

  localparam int unsigned NEST_MAX    = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 450;
  localparam int unsigned NUM_DIRECTED = 25;

  // Status of one byte, as the block reports it.
  typedef struct packed {
    logic       finished;
    logic       doc_ok;
    logic       err_seen;
    logic [6:0] depth;
  } verdict_t;

  // One row of the directed table. Where typed is set, want is the expected
  // status; elsewhere the bench parser supplies it.
  typedef struct packed {
    logic [7:0] chr;
    logic       typed;
    verdict_t   want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_last;

  // While set, neither side of the bench inserts gaps or stalls.
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cyc;

  verdict_t    verdict_q[$];
  logic [7:0]  text_q[$];

  // Bench parser state.
  phase_e              p_phase = PH_VALUE;
  logic [3:0]          p_lit = '0;
  logic [NEST_MAX-1:0] p_kinds = '0;
  int unsigned         p_depth = 0;
  logic                p_err = 1'b0;

  always #4 clk_i = ~clk_i;

  json_syntax_validator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  // --------------------------------------------------------------------------
  // Bench parser
  // --------------------------------------------------------------------------

  function automatic bit is_space(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Opening a container past the stack depth is an error, and the state
  // stays where it was.
  function automatic void open_level(logic kind, phase_e nxt);
    if (p_depth >= NEST_MAX) begin
      p_err = 1'b1;
    end else begin
      p_kinds[p_depth] = kind;
      p_depth++;
      p_phase = nxt;
    end
  endfunction

  function automatic void close_level();
    if (p_depth > 0) p_depth--;
    p_phase = PH_AFTER;
  endfunction

  function automatic void begin_value(logic [7:0] c);
    if (c == CH_QUOTE) p_phase = PH_VAL_STR;
    else if (c == CH_LBRACE) open_level(KIND_OBJECT, PH_OBJ_FIRST);
    else if (c == CH_LBRACK) open_level(KIND_ARRAY, PH_ARR_FIRST);
    else if (c == CH_MINUS) p_phase = PH_NUM_SIGN;
    else if (is_num(c)) p_phase = PH_NUM_INT;
    else if (c == CH_T) begin
      p_phase = PH_LIT_TRUE;
      p_lit = 4'd1;
    end else if (c == CH_F) begin
      p_phase = PH_LIT_FALSE;
      p_lit = 4'd1;
    end else if (c == CH_N) begin
      p_phase = PH_LIT_NULL;
      p_lit = 4'd1;
    end else p_err = 1'b1;
  endfunction

  // A complete value has been seen: a separator, a matching closer or
  // whitespace may follow, and only inside a container.
  function automatic void follow_value(logic [7:0] c);
    logic kind;
    if (is_space(c)) return;
    if (p_depth == 0 || p_depth > NEST_MAX) begin
      p_err = 1'b1;
      return;
    end
    kind = p_kinds[p_depth-1];
    if (c == CH_COMMA) begin
      p_phase = (kind == KIND_OBJECT) ? PH_OBJ_KEY : PH_VALUE;
    end else if ((kind == KIND_OBJECT && c == CH_RBRACE) ||
                 (kind == KIND_ARRAY && c == CH_RBRACK)) begin
      close_level();
    end else begin
      p_err = 1'b1;
    end
  endfunction

  function automatic void advance_phase(logic [7:0] c);
    string word;
    case (p_phase)
      PH_VALUE: if (!is_space(c)) begin_value(c);
      PH_ARR_FIRST: begin
        if (c == CH_RBRACK) close_level();
        else if (!is_space(c)) begin_value(c);
      end
      PH_OBJ_FIRST, PH_OBJ_KEY: begin
        if (c == CH_RBRACE && p_phase == PH_OBJ_FIRST) close_level();
        else if (c == CH_QUOTE) p_phase = PH_KEY_STR;
        else if (!is_space(c)) p_err = 1'b1;
      end
      PH_KEY_STR: begin
        if (c == CH_QUOTE) p_phase = PH_COLON;
        else if (c == CH_BSLASH) p_phase = PH_KEY_ESC;
      end
      PH_KEY_ESC: p_phase = PH_KEY_STR;
      PH_COLON: begin
        if (c == CH_COLON) p_phase = PH_VALUE;
        else if (!is_space(c)) p_err = 1'b1;
      end
      PH_VAL_STR: begin
        if (c == CH_QUOTE) p_phase = PH_AFTER;
        else if (c == CH_BSLASH) p_phase = PH_VAL_ESC;
      end
      PH_VAL_ESC: p_phase = PH_VAL_STR;
      PH_NUM_SIGN: begin
        if (is_num(c)) p_phase = PH_NUM_INT;
        else p_err = 1'b1;
      end
      PH_NUM_INT, PH_NUM_FRAC: begin
        // The byte that ends a number is taken as the byte after a value.
        if (c == CH_DOT && p_phase == PH_NUM_INT) p_phase = PH_NUM_FRAC;
        else if (!is_num(c)) begin
          p_phase = PH_AFTER;
          follow_value(c);
        end
      end
      PH_LIT_TRUE, PH_LIT_FALSE, PH_LIT_NULL: begin
        if (p_phase == PH_LIT_TRUE) word = "true";
        else if (p_phase == PH_LIT_FALSE) word = "false";
        else word = "null";
        if (p_lit >= word.len() || word[p_lit] != c) begin
          p_err = 1'b1;
        end else begin
          p_lit++;
          if (p_lit == word.len()) begin
            p_lit = '0;
            p_phase = PH_AFTER;
          end
        end
      end
      default: follow_value(c);
    endcase
  endfunction

  // Status word for one byte; the terminator gives the verdict and clears
  // the parser. Once an error is seen, bytes up to the terminator are ignored.
  function automatic verdict_t parse_byte(logic [7:0] c);
    verdict_t v;
    logic     ok;
    if (c == CH_NUL) begin
      ok = (p_phase inside {PH_AFTER, PH_NUM_INT, PH_NUM_FRAC}) && !p_err && p_depth == 0;
      v.finished = 1'b1;
      v.doc_ok   = ok;
      v.err_seen = !ok;
      v.depth    = p_depth[6:0];
      p_phase = PH_VALUE;
      p_lit   = '0;
      p_depth = 0;
      p_err   = 1'b0;
      return v;
    end
    if (!p_err) advance_phase(c);
    v.finished = 1'b0;
    v.doc_ok   = 1'b0;
    v.err_seen = p_err;
    v.depth    = p_depth[6:0];
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Text generation; the tasks build the document in text_q.
  // --------------------------------------------------------------------------

  task automatic add_ws();
    logic [7:0] spaces [4];
    spaces = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) text_q.push_back(spaces[$urandom_range(0, 3)]);
    end
  endtask

  // Any byte but the terminator may sit in a string; quotes and backslashes
  // in the content are escaped, and some escapes take an arbitrary byte.
  task automatic add_string();
    logic [7:0] b;
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 4)) begin
      b = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 7) == 0 || b == CH_QUOTE || b == CH_BSLASH) begin
        text_q.push_back(CH_BSLASH);
      end
      text_q.push_back(b);
    end
    text_q.push_back(CH_QUOTE);
  endtask

  task automatic add_key();
    add_ws();
    add_string();
    add_ws();
    text_q.push_back(CH_COLON);
  endtask

  task automatic add_scalar();
    string word;
    case ($urandom_range(0, 2))
      0: add_string();
      1: begin
        if ($urandom_range(0, 2) == 0) text_q.push_back(CH_MINUS);
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        if ($urandom_range(0, 2) == 0) begin
          text_q.push_back(CH_DOT);
          repeat ($urandom_range(0, 2)) text_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
      end
      default: begin
        if ($urandom_range(0, 2) == 0) word = "true";
        else if ($urandom_range(0, 1) == 0) word = "false";
        else word = "null";
        for (int i = 0; i < word.len(); i++) text_q.push_back(word[i]);
      end
    endcase
  endtask

  // Well-formed document with containers up to max_lvl deep; budget bounds
  // the number of values so that the document stays short.
  task automatic build_doc(input int max_lvl, input int budget);
    bit lvl_kind[$];
    bit want_value;
    bit done;
    want_value = 1'b1;
    done = 1'b0;
    while (!done) begin
      if (want_value) begin
        add_ws();
        budget--;
        if (lvl_kind.size() < max_lvl && budget > 0 && $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 1) == 1) begin
            text_q.push_back(CH_LBRACE);
            lvl_kind.push_back(KIND_OBJECT);
            if ($urandom_range(0, 4) == 0) begin
              add_ws();
              text_q.push_back(CH_RBRACE);
              void'(lvl_kind.pop_back());
              want_value = 1'b0;
            end else begin
              add_key();
            end
          end else begin
            text_q.push_back(CH_LBRACK);
            lvl_kind.push_back(KIND_ARRAY);
            if ($urandom_range(0, 4) == 0) begin
              add_ws();
              text_q.push_back(CH_RBRACK);
              void'(lvl_kind.pop_back());
              want_value = 1'b0;
            end
          end
        end else begin
          add_scalar();
          want_value = 1'b0;
        end
      end else if (lvl_kind.size() == 0) begin
        done = 1'b1;
      end else begin
        add_ws();
        if (budget > 0 && $urandom_range(0, 1) == 1) begin
          text_q.push_back(CH_COMMA);
          if (lvl_kind[$] == KIND_OBJECT) add_key();
          want_value = 1'b1;
        end else begin
          text_q.push_back(lvl_kind[$] == KIND_OBJECT ? CH_RBRACE : CH_RBRACK);
          void'(lvl_kind.pop_back());
        end
      end
    end
    add_ws();
  endtask

  // Breaks a well-formed document now and then: a cut anywhere (which ends
  // strings, escapes, numbers and literals early), a byte overwritten, a
  // trailing comma before a closer, or plain noise.
  task automatic damage_doc();
    int unsigned mode;
    int          pos;
    mode = $urandom_range(0, 99);
    if (mode < 70) return;
    if (mode < 78) begin
      pos = $urandom_range(0, text_q.size() - 1);
      while (text_q.size() > pos) void'(text_q.pop_back());
    end else if (mode < 86) begin
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
    end else if (mode < 93) begin
      pos = text_q.size() - 1;
      while (pos > 0 && !(text_q[pos] inside {CH_RBRACE, CH_RBRACK})) pos--;
      text_q.insert(pos, CH_COMMA);
    end else begin
      text_q.delete();
      repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driving and checking
  // --------------------------------------------------------------------------

  // Called at a falling edge. Offers one word, possibly after a gap, records
  // its expected status at the accepting edge and returns at the next falling
  // edge. A typed expectation replaces the parser's, which still advances.
  task automatic send_byte(input logic [7:0] b, input logic typed, input verdict_t want);
    verdict_t v;
    while (!calm && $urandom_range(0, 99) < 26) begin
      s_valid <= 1'b0;
      s_data  <= 8'($urandom());
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    v = parse_byte(b);
    verdict_q.push_back(typed ? want : v);
    @(negedge clk_i);
  endtask

  // Sends text_q followed by the terminator.
  task automatic send_doc(inout int unsigned count);
    foreach (text_q[i]) send_byte(text_q[i], 1'b0, '0);
    send_byte(CH_NUL, 1'b0, '0);
    count += text_q.size() + 1;
    text_q.delete();
  endtask

  function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // The result side stalls at random except in calm stretches.
  always @(negedge clk_i) begin
    m_ready <= calm || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (verdict_q.size() == 0) begin
        $error("result word with no byte pending: tdata %h tlast %b", m_data, m_last);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("finished", 7'(want.finished), 7'(m_last));
        check_field("document_valid", 7'(want.doc_ok), 7'(m_data[0]));
        check_field("error_seen", 7'(want.err_seen), 7'(m_data[1]));
        check_field("nesting_depth", want.depth, m_data[8:2]);
        check_field("tdata pad", 7'd0, m_data[15:9]);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("json_syntax_validator: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Terminator and bad byte right after reset, a full document with an
  // escaped quote in a key, a signed number and a literal, a number that
  // runs into the terminator, and a leading comma with a container open.
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{CH_NUL,    1'b1, '{1'b1, 1'b0, 1'b1, 7'd0}},
    '{8'hFF,     1'b1, '{1'b0, 1'b0, 1'b1, 7'd0}},
    '{CH_NUL,    1'b1, '{1'b1, 1'b0, 1'b1, 7'd0}},
    '{CH_LBRACE, 1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},
    '{CH_BSLASH, 1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},
    '{CH_QUOTE,  1'b0, '0},
    '{CH_COLON,  1'b0, '0},
    '{CH_LBRACK, 1'b0, '0},
    '{CH_MINUS,  1'b0, '0},
    '{8'h31,     1'b0, '0},
    '{CH_COMMA,  1'b0, '0},
    '{CH_N,      1'b0, '0},
    '{CH_U,      1'b0, '0},
    '{CH_L,      1'b0, '0},
    '{CH_L,      1'b0, '0},
    '{CH_RBRACK, 1'b0, '0},
    '{CH_RBRACE, 1'b0, '0},
    '{CH_NUL,    1'b1, '{1'b1, 1'b1, 1'b0, 7'd0}},
    '{8'h37,     1'b0, '0},
    '{CH_NUL,    1'b1, '{1'b1, 1'b1, 1'b0, 7'd0}},
    '{CH_LBRACK, 1'b0, '0},
    '{CH_COMMA,  1'b0, '0},
    '{CH_NUL,    1'b1, '{1'b1, 1'b0, 1'b1, 7'd1}}
  };

  initial begin
    int unsigned sent;
    int unsigned docs;
    bit          deep_kind[NEST_MAX];
    sent = 0;
    docs = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i].chr, DIRECTED[i].typed, DIRECTED[i].want);

    while (sent < RANDOM_BYTES) begin
      if (docs == 6) begin
        // Long stretch without gaps or stalls around the nesting limit: a
        // document exactly at the stack depth, then one that goes past it.
        calm = 1'b1;
        for (int i = 0; i < NEST_MAX; i++) begin
          deep_kind[i] = $urandom_range(0, 1);
          if (deep_kind[i] == KIND_OBJECT) begin
            text_q.push_back(CH_LBRACE);
            text_q.push_back(CH_QUOTE);
            text_q.push_back(CH_QUOTE);
            text_q.push_back(CH_COLON);
          end else begin
            text_q.push_back(CH_LBRACK);
          end
        end
        text_q.push_back(CH_ZERO);
        for (int i = NEST_MAX - 1; i >= 0; i--) begin
          text_q.push_back(deep_kind[i] == KIND_OBJECT ? CH_RBRACE : CH_RBRACK);
        end
        send_doc(sent);
        repeat (NEST_MAX + 1) text_q.push_back(CH_LBRACK);
        text_q.push_back(CH_RBRACK);
        send_doc(sent);
        calm = 1'b0;
      end
      build_doc($urandom_range(0, 4), $urandom_range(1, 8));
      damage_doc();
      send_doc(sent);
      docs++;
    end
    s_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("json_syntax_validator: match");
    end else begin
      $display("json_syntax_validator: mismatch");
    end
    $finish;
  end

endmodule
